/* src/life_generation_torus_defines.svh */
// ----------------------------------------------------------------------------
// life_generation_torus_defines
// assertion macros shared by the life generation block
// ----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_TORUS_DEFINES_SVH
`define LIFE_GENERATION_TORUS_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LGT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("life generation assertion failed");

// next-cycle implication, checked out of reset
`define LGT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("life generation assertion failed");

`endif

/* src/lgt_pkg.sv */
// ----------------------------------------------------------------------------
// lgt_pkg
// widths and rule constants for the life generation block
// ----------------------------------------------------------------------------
package lgt_pkg;

    localparam int DATA_W    = 64;
    localparam int ROW_W     = 6;
    localparam int SUM_W     = 4;

    // b3/s23 written as a 3x3 block sum including the center cell
    localparam logic [SUM_W-1:0] BIRTH_SUM = 4'd3;
    localparam logic [SUM_W-1:0] KEEP_SUM  = 4'd4;

endpackage

/* src/lgt_cell.sv */
// ----------------------------------------------------------------------------
// lgt_cell
// one row register of the grid shift chain
// ----------------------------------------------------------------------------
module lgt_cell #(
    parameter int SIDE = 64
) (
    input  logic            clk,
    input  logic            shift_en,
    input  logic [SIDE-1:0] d,
    output logic [SIDE-1:0] q
);

    logic [SIDE-1:0] row_reg;
    logic [SIDE-1:0] row_next;

    always_comb
    begin
        row_next = row_reg;
        if (shift_en)
        begin
            row_next = d;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
    end

    assign q = row_reg;

endmodule

/* src/lgt_rule.sv */
// ----------------------------------------------------------------------------
// lgt_rule
// next generation of one row from the rows above, at and below it
// ----------------------------------------------------------------------------
module lgt_rule #(
    parameter int SIDE = 64
) (
    input  logic [SIDE-1:0] up,
    input  logic [SIDE-1:0] mid,
    input  logic [SIDE-1:0] dn,
    output logic [SIDE-1:0] nxt
);

    for (genvar c = 0; c < SIDE; c++)
    begin : g_col
        // columns wrap around the torus
        localparam int LF = (c + SIDE - 1) % SIDE;
        localparam int RT = (c + 1) % SIDE;

        logic [lgt_pkg::SUM_W-1:0] sum;

        always_comb
        begin
            sum = lgt_pkg::SUM_W'(up[LF])  + lgt_pkg::SUM_W'(up[c])  + lgt_pkg::SUM_W'(up[RT])
                + lgt_pkg::SUM_W'(mid[LF]) + lgt_pkg::SUM_W'(mid[c]) + lgt_pkg::SUM_W'(mid[RT])
                + lgt_pkg::SUM_W'(dn[LF])  + lgt_pkg::SUM_W'(dn[c])  + lgt_pkg::SUM_W'(dn[RT]);
            nxt[c] = (sum == lgt_pkg::BIRTH_SUM)
                  || ((sum == lgt_pkg::KEEP_SUM) && mid[c]);
        end
    end

endmodule

/* src/life_generation_torus.sv */
// ----------------------------------------------------------------------------
// life_generation_torus
// one b3/s23 life generation on a square torus, grid in and out row by row
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------
//  in      | in_valid, in_stall  | row_cells
//  out     | out_valid, out_stall| next_row_cells, row_number, final_row
//
//  a frame loads GRID_SIDE rows, one row transfer per cycle while in_valid is high
//  it then emits GRID_SIDE rows, one per cycle while out_stall is low
//  the row chain rotates once per emitted row; rows above, at and below
//  the current row sit at fixed cells of the chain
//  in_stall is high during emission; out_stall holds the output register
//  reset returns to loading with an empty frame; no clearing pass
// ----------------------------------------------------------------------------
`include "life_generation_torus_defines.svh"

module life_generation_torus #(
    parameter int GRID_SIDE = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [lgt_pkg::DATA_W-1:0]  row_cells,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [lgt_pkg::DATA_W-1:0]  next_row_cells,
    output logic [lgt_pkg::ROW_W-1:0]   row_number,
    output logic                        final_row
);

    localparam int CNT_W = $clog2(GRID_SIDE);
    localparam logic [CNT_W-1:0] LAST_ROW = CNT_W'(GRID_SIDE - 1);

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           cnt_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [lgt_pkg::DATA_W-1:0] out_row_reg;
    logic [lgt_pkg::DATA_W-1:0] out_row_next;
    logic [lgt_pkg::ROW_W-1:0]  out_num_reg;
    logic [lgt_pkg::ROW_W-1:0]  out_num_next;
    logic                       out_last_reg;
    logic                       out_last_next;

    logic                       in_xfer;
    logic                       emit_step;
    logic                       shift_en;
    logic [GRID_SIDE-1:0]       tail_d;
    logic [GRID_SIDE-1:0]       grid_q [GRID_SIDE];
    logic [GRID_SIDE-1:0]       rule_row;

    assign in_stall  = (state_reg != ST_LOAD);
    assign in_xfer   = in_valid && !in_stall;
    assign emit_step = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign shift_en  = in_xfer || emit_step;

    // loading pushes new rows in at the tail, emitting rotates the chain
    assign tail_d = (state_reg == ST_LOAD) ? row_cells[GRID_SIDE-1:0] : grid_q[0];

    for (genvar i = 0; i < GRID_SIDE; i++)
    begin : g_cell
        logic [GRID_SIDE-1:0] cell_d;

        if (i == GRID_SIDE - 1)
        begin : g_tail
            assign cell_d = tail_d;
        end
        else
        begin : g_body
            assign cell_d = grid_q[i+1];
        end

        lgt_cell #(
            .SIDE     (GRID_SIDE)
        ) u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .d        (cell_d),
            .q        (grid_q[i])
        );
    end

    // cell 0 holds the row being emitted, its neighbors wrap through the chain
    lgt_rule #(
        .SIDE (GRID_SIDE)
    ) u_rule (
        .up   (grid_q[GRID_SIDE-1]),
        .mid  (grid_q[0]),
        .dn   (grid_q[1]),
        .nxt  (rule_row)
    );

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_row_next   = out_row_reg;
        out_num_next   = out_num_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (cnt_reg == LAST_ROW)
                    begin
                        cnt_next   = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_EMIT:
            begin
                if (emit_step)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = lgt_pkg::DATA_W'(rule_row);
                    out_num_next   = lgt_pkg::ROW_W'(cnt_reg);
                    out_last_next  = (cnt_reg == LAST_ROW);
                    if (cnt_reg == LAST_ROW)
                    begin
                        cnt_next   = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_row_reg  <= out_row_next;
        out_num_reg  <= out_num_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid      = out_valid_reg;
    assign next_row_cells = out_row_reg;
    assign row_number     = out_num_reg;
    assign final_row      = out_last_reg;

    `LGT_ASSERT_NOW(a_final_is_last_row, out_valid && final_row,
        row_number == lgt_pkg::ROW_W'(GRID_SIDE - 1))
    `LGT_ASSERT_NEXT(a_frame_starts_emit, in_xfer && (cnt_reg == LAST_ROW),
        state_reg == ST_EMIT)
    `LGT_ASSERT_NEXT(a_rows_in_sequence, out_valid && !out_stall && !final_row,
        out_valid && (row_number == lgt_pkg::ROW_W'($past(row_number) + 1'b1)))
    // a long stall on the last row may overlap the next frame's load
    `LGT_ASSERT_NEXT(a_burst_ends, out_valid && !out_stall && final_row,
        !out_valid || (row_number == '0))

endmodule
